/* rtl/sve_pkg.sv */
// Shared types, codes and envelope update functions for the volume envelope block.
`default_nettype none

package sve_pkg;

   typedef enum logic [1:0] {
      ACT_WRITE  = 2'd0,
      ACT_TICK   = 2'd1,
      ACT_EXPIRE = 2'd2
   } action_type;

   localparam logic [2:0] REG_ENVELOPE = 3'd2;
   localparam logic [2:0] REG_CONTROL  = 3'd4;

   localparam logic [3:0] TIMER_FULL = 4'd8;
   localparam logic [3:0] LEVEL_MAX  = 4'hF;
   localparam logic [3:0] LEVEL_MIN  = 4'h0;

   typedef struct packed {
      logic [1:0] action;
      logic [2:0] reg_index;
      logic [7:0] write_data;
   } req_item_type;

   typedef struct packed {
      logic [3:0] output_level;
      logic [3:0] envelope_level;
      logic       envelope_running;
      logic       trigger_taken;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0] env_reg;
      logic [3:0] period_timer;
      logic [3:0] stop_level;
      logic [3:0] clamp_level;
      logic       running;
      logic [2:0] step_period;
      logic       step_up;
      logic [7:0] step_countdown;
   } env_state_type;

   // Reload the period timer and the clamp stepper from the envelope register.
   function automatic env_state_type env_reload(env_state_type s);
      env_state_type n;
      logic [2:0]    raw;
      n   = s;
      raw = s.env_reg[2:0];
      n.period_timer   = (raw == 3'd0) ? TIMER_FULL : {1'b0, raw};
      n.step_period    = raw;
      n.step_up        = s.env_reg[3];
      n.step_countdown = {5'd0, raw};
      return n;
   endfunction

   // One envelope clock tick.
   function automatic env_state_type env_tick(env_state_type s);
      env_state_type n;
      n = s;
      if (n.running) begin
         if (n.period_timer <= 4'd1) begin
            n = env_reload(n);
            if (n.step_period != 3'd0) begin
               if (n.env_reg[3]) begin
                  if (n.stop_level != LEVEL_MAX) begin
                     n.stop_level = n.stop_level + 4'd1;
                  end else begin
                     n.running = 1'b0;
                  end
               end else begin
                  if (n.stop_level != LEVEL_MIN) begin
                     n.stop_level = n.stop_level - 4'd1;
                  end else begin
                     n.running = 1'b0;
                  end
               end
            end
         end else begin
            n.period_timer = n.period_timer - 4'd1;
         end
      end
      if (n.step_period != 3'd0) begin
         n.step_countdown = n.step_countdown - 8'd1;
         if (n.step_countdown == 8'd0) begin
            n.step_countdown = {5'd0, n.step_period};
            if (n.step_up) begin
               if (n.clamp_level != LEVEL_MAX) n.clamp_level = n.clamp_level + 4'd1;
            end else if (n.clamp_level != LEVEL_MIN) begin
               n.clamp_level = n.clamp_level - 4'd1;
            end
         end
      end
      return n;
   endfunction

   // Zombie-mode volume adjustment on an envelope write (mod 16 arithmetic).
   function automatic logic [3:0] zombie_level(logic [3:0] level, logic [7:0] prev,
                                               logic [7:0] data);
      logic [3:0] v;
      v = level;
      if (prev[3] != data[3]) begin
         if (!prev[3]) begin
            v = v + 4'd1;
            if (prev[2:0] != 3'd0) v = v + 4'd1;
         end
         v = 4'd0 - v;
      end else if (prev[3:0] == 4'h8) begin
         v = v + 4'd1;
      end
      return v;
   endfunction

endpackage

`default_nettype wire

/* rtl/sve_if.sv */
// Valid/ready channel interfaces for requests and responses.
`default_nettype none

interface sve_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [2:0] reg_index;
   logic [7:0] write_data;

   modport source (output valid, output action, output reg_index, output write_data,
                   input ready);
   modport sink   (input valid, input action, input reg_index, input write_data,
                   output ready);
endinterface

interface sve_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] output_level;
   logic [3:0] envelope_level;
   logic       envelope_running;
   logic       trigger_taken;

   modport source (output valid, output output_level, output envelope_level,
                   output envelope_running, output trigger_taken, input ready);
   modport sink   (input valid, input output_level, input envelope_level,
                   input envelope_running, input trigger_taken, output ready);
endinterface

`default_nettype wire

/* rtl/sound_volume_envelope.sv */
// Volume envelope of one sound channel: top level with input and result registers.
//
// Usage:
//   req_ch carries one transaction per item: action (register write, envelope
//   clock tick or length expiry), reg_index and write_data. rsp_ch returns
//   exactly one result per request: the clamped output level, the envelope
//   level, the running flag and whether the write triggered the channel.
//   A request accepted into the input register is applied to the envelope
//   state, and its result loaded into the result register, once that
//   register is free or being read. Throughput is one request per cycle
//   while rsp_ch.ready is high; the update is a single short
//   combinational pass between the input register and the result register.
//   When the receiver holds rsp_ch.ready low, the result register holds its
//   transaction, one more request may wait in the input register, and
//   req_ch.ready drops until a result is taken.
//   Reset (synchronous, active high) clears the envelope register, timers,
//   levels and flags to zero and empties both registers.
`default_nettype none

module sound_volume_envelope
   import sve_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   sve_req_if.sink   req_ch,
   sve_rsp_if.source rsp_ch
);

   req_item_type in_item_ff;
   logic         in_vld_ff;
   logic         in_vld_in;
   rsp_item_type out_item_ff;
   logic         out_vld_ff;
   logic         out_vld_in;
   rsp_item_type result_in;
   logic         advance;
   logic         req_take;

   assign advance      = in_vld_ff && (!out_vld_ff || rsp_ch.ready);
   assign req_ch.ready = !in_vld_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;

   assign in_vld_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_vld_ff);
   assign out_vld_in = advance ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_vld_ff);

   sve_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .item      (in_item_ff),
      .result_in (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
      if (req_take) begin
         in_item_ff.action     <= req_ch.action;
         in_item_ff.reg_index  <= req_ch.reg_index;
         in_item_ff.write_data <= req_ch.write_data;
      end
      if (advance) begin
         out_item_ff <= result_in;
      end
   end

   assign rsp_ch.valid            = out_vld_ff;
   assign rsp_ch.output_level     = out_item_ff.output_level;
   assign rsp_ch.envelope_level   = out_item_ff.envelope_level;
   assign rsp_ch.envelope_running = out_item_ff.envelope_running;
   assign rsp_ch.trigger_taken    = out_item_ff.trigger_taken;

endmodule

`default_nettype wire

/* rtl/sve_core.sv */
// Envelope state registers and the single-pass update for one transaction.
`default_nettype none

module sve_core
   import sve_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         step,
   input  wire req_item_type item,
   output rsp_item_type      result_in
);

   env_state_type state_ff;
   env_state_type state_in;
   env_state_type pre;
   logic          trig;

   always_comb begin
      state_in = state_ff;
      pre      = state_ff;
      trig     = 1'b0;
      case (action_type'(item.action))
         ACT_WRITE: begin
            if (item.reg_index == REG_ENVELOPE) begin
               if (item.write_data[7:3] == 5'd0) begin
                  state_in.clamp_level = LEVEL_MIN;
                  state_in.running     = 1'b0;
               end else begin
                  pre.clamp_level = zombie_level(state_ff.clamp_level, state_ff.env_reg,
                                                 item.write_data);
                  state_in = pre;
                  if (item.write_data[2:0] != 3'd0 && state_ff.period_timer == TIMER_FULL)
                  begin
                     pre.clamp_level    = item.write_data[7:4];
                     pre.step_period    = item.write_data[2:0];
                     pre.step_up        = item.write_data[3];
                     pre.step_countdown = item.write_data;
                     pre.period_timer   = 4'd1;
                     // tick still sees the old envelope register
                     state_in = env_tick(pre);
                  end
               end
               state_in.env_reg = item.write_data;
            end else if (item.reg_index == REG_CONTROL && item.write_data[7]) begin
               trig = 1'b1;
               pre.stop_level  = state_ff.env_reg[7:4];
               pre.clamp_level = state_ff.env_reg[7:4];
               pre.running     = 1'b1;
               state_in = env_reload(pre);
               if (state_ff.env_reg[7:3] == 5'd0) begin
                  state_in.clamp_level = LEVEL_MIN;
                  state_in.running     = 1'b0;
               end
            end
         end
         ACT_TICK: begin
            state_in = env_tick(state_ff);
         end
         ACT_EXPIRE: begin
            state_in.stop_level = LEVEL_MIN;
            state_in.running    = 1'b0;
         end
         default: begin
            state_in = state_ff;
         end
      endcase
   end

   assign result_in.output_level     = state_in.clamp_level;
   assign result_in.envelope_level   = state_in.stop_level;
   assign result_in.envelope_running = state_in.running;
   assign result_in.trigger_taken    = trig;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (step) begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for the sound channel volume envelope block.
`default_nettype none

module tb;
   import sve_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] ACT_UNUSED   = 2'd3;
   localparam int         RANDOM_ITEMS = 1000;
   localparam int         STALL_LIMIT  = 2000;
   localparam int         DRAIN_CYCLES = 4;

   logic clock = 1'b0;
   logic reset;
   bit   calm;

   sve_req_if req_ch();
   sve_rsp_if rsp_ch();

   sound_volume_envelope u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predicted channel state
   logic [7:0] env_reg_q;
   logic [3:0] period_cnt;
   logic [3:0] env_vol;
   logic [3:0] out_vol;
   logic       env_on;
   logic [2:0] clamp_period;
   logic       clamp_up;
   logic [7:0] clamp_cnt;

   rsp_item_type expected_levels[$];

   int n_fail;
   int n_effective;
   int n_writes;
   int n_ticks;
   int n_triggers;
   int n_expiries;
   int n_ignored;

   function automatic void clear_channel();
      env_reg_q    = '0;
      period_cnt   = '0;
      env_vol      = '0;
      out_vol      = '0;
      env_on       = 1'b0;
      clamp_period = '0;
      clamp_up     = 1'b0;
      clamp_cnt    = '0;
   endfunction

   // Returns 1 when the register holds a nonzero period.
   function automatic logic reload_period();
      logic [2:0] p;
      p            = env_reg_q[2:0];
      period_cnt   = (p == 3'd0) ? TIMER_FULL : {1'b0, p};
      clamp_period = p;
      clamp_up     = env_reg_q[3];
      clamp_cnt    = {5'd0, p};
      return p != 3'd0;
   endfunction

   function automatic void envelope_clock();
      if (env_on) begin
         if (period_cnt > 4'd1) begin
            period_cnt = period_cnt - 4'd1;
         end else if (reload_period()) begin
            if (env_reg_q[3]) begin
               if (env_vol < LEVEL_MAX) begin
                  env_vol = env_vol + 4'd1;
               end else begin
                  env_on  = 1'b0;
                  env_vol = LEVEL_MAX;
               end
            end else if (env_vol > LEVEL_MIN) begin
               env_vol = env_vol - 4'd1;
            end else begin
               env_on  = 1'b0;
               env_vol = LEVEL_MIN;
            end
         end
      end
      // free-running clamped copy, saturates instead of stopping
      if (clamp_period != 3'd0) begin
         clamp_cnt = clamp_cnt - 8'd1;
         if (clamp_cnt == 8'd0) begin
            clamp_cnt = {5'd0, clamp_period};
            if (clamp_up) begin
               if (out_vol != LEVEL_MAX) out_vol = out_vol + 4'd1;
            end else if (out_vol != LEVEL_MIN) begin
               out_vol = out_vol - 4'd1;
            end
         end
      end
   endfunction

   // Volume change caused by rewriting the envelope register while playing.
   function automatic logic [3:0] rewrite_volume(logic [3:0] vol, logic [7:0] prev,
                                                 logic [7:0] data);
      logic [4:0] v;
      v = {1'b0, vol};
      if (prev[3] != data[3]) begin
         if (!prev[3]) v = v + ((prev[2:0] != 3'd0) ? 5'd2 : 5'd1);
         v = 5'd16 - v;
      end else if (prev[3:0] == 4'h8) begin
         v = v + 5'd1;
      end
      return v[3:0];
   endfunction

   function automatic rsp_item_type predict_levels(req_item_type it);
      rsp_item_type r;
      logic         trig;
      trig = 1'b0;
      case (it.action)
         ACT_WRITE: begin
            if (it.reg_index == REG_ENVELOPE) begin
               if (it.write_data[7:3] == 5'd0) begin
                  // DAC off
                  out_vol = LEVEL_MIN;
                  env_on  = 1'b0;
               end else begin
                  out_vol = rewrite_volume(out_vol, env_reg_q, it.write_data);
                  if (it.write_data[2:0] != 3'd0 && period_cnt == TIMER_FULL) begin
                     out_vol      = it.write_data[7:4];
                     clamp_period = it.write_data[2:0];
                     clamp_up     = it.write_data[3];
                     clamp_cnt    = it.write_data;
                     period_cnt   = 4'd1;
                     envelope_clock();   // still with the old register value
                  end
               end
               env_reg_q = it.write_data;
            end else if (it.reg_index == REG_CONTROL && it.write_data[7]) begin
               trig    = 1'b1;
               env_vol = env_reg_q[7:4];
               out_vol = env_reg_q[7:4];
               void'(reload_period());
               env_on  = 1'b1;
               if (env_reg_q[7:3] == 5'd0) begin
                  out_vol = LEVEL_MIN;
                  env_on  = 1'b0;
               end
            end
         end
         ACT_TICK: begin
            envelope_clock();
         end
         ACT_EXPIRE: begin
            env_vol = LEVEL_MIN;
            env_on  = 1'b0;
         end
         default: ;
      endcase
      r.output_level     = out_vol;
      r.envelope_level   = env_vol;
      r.envelope_running = env_on;
      r.trigger_taken    = trig;
      return r;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_item(input logic [1:0] act, input logic [2:0] idx,
                            input logic [7:0] data);
      req_item_type it;
      it.action     = act;
      it.reg_index  = idx;
      it.write_data = data;
      while (!calm && $urandom_range(0, 99) < 20) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.action     <= act;
      req_ch.reg_index  <= idx;
      req_ch.write_data <= data;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_levels.push_back(predict_levels(it));
      case (act)
         ACT_WRITE: begin
            if (idx == REG_ENVELOPE) begin
               n_writes++;
               n_effective++;
            end else if (idx == REG_CONTROL && data[7]) begin
               n_triggers++;
               n_effective++;
            end else begin
               n_ignored++;
            end
         end
         ACT_TICK: begin
            n_ticks++;
            n_effective++;
         end
         ACT_EXPIRE: begin
            n_expiries++;
            n_effective++;
         end
         default: n_ignored++;
      endcase
      @(negedge clock);
   endtask

   function automatic logic [7:0] random_envelope();
      logic [7:0] d;
      d = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 9) == 0) d[7:3] = 5'd0;
      if ($urandom_range(0, 3) == 0) d[2:0] = 3'd0;
      return d;
   endfunction

   task automatic send_noise();
      logic [2:0] idx;
      case ($urandom_range(0, 2))
         0: send_item(ACT_UNUSED, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
         1: begin
            do idx = 3'($urandom_range(0, 7));
            while (idx == REG_ENVELOPE || idx == REG_CONTROL);
            send_item(ACT_WRITE, idx, 8'($urandom_range(0, 255)));
         end
         default: send_item(ACT_WRITE, REG_CONTROL, 8'($urandom_range(0, 127)));
      endcase
   endtask

   task automatic test_quiet_events();
      send_item(ACT_TICK, 3'd0, 8'h00);
      send_item(ACT_EXPIRE, 3'd7, 8'hFF);
      send_item(ACT_UNUSED, REG_ENVELOPE, 8'hFF);
      send_item(ACT_WRITE, 3'd0, 8'hFF);
      send_item(ACT_WRITE, 3'd7, 8'h00);
      send_item(ACT_WRITE, REG_CONTROL, 8'h7F);
   endtask

   task automatic test_dac_off();
      send_item(ACT_WRITE, REG_CONTROL, 8'h80);
      send_item(ACT_WRITE, REG_ENVELOPE, 8'h07);
      send_item(ACT_WRITE, REG_CONTROL, 8'hFF);
   endtask

   task automatic test_zombie_writes();
      send_item(ACT_WRITE, REG_ENVELOPE, 8'h10);
      send_item(ACT_WRITE, REG_ENVELOPE, 8'h18);   // down to up, no period
      send_item(ACT_WRITE, REG_ENVELOPE, 8'h18);   // same direction, low nibble 8
      send_item(ACT_WRITE, REG_ENVELOPE, 8'h13);   // up to down
      send_item(ACT_WRITE, REG_ENVELOPE, 8'h1B);   // down to up with period
      send_item(ACT_WRITE, REG_ENVELOPE, 8'hF8);
      send_item(ACT_WRITE, REG_CONTROL, 8'h80);
      send_item(ACT_WRITE, REG_ENVELOPE, 8'hF9);   // timer full: immediate step
   endtask

   task automatic test_level_limits();
      send_item(ACT_WRITE, REG_ENVELOPE, 8'hE9);
      send_item(ACT_WRITE, REG_CONTROL, 8'h80);
      repeat (3) send_item(ACT_TICK, 3'd0, 8'h00);
      send_item(ACT_WRITE, REG_ENVELOPE, 8'h11);
      send_item(ACT_WRITE, REG_CONTROL, 8'hC0);
      repeat (3) send_item(ACT_TICK, 3'd0, 8'h00);
      send_item(ACT_EXPIRE, 3'd0, 8'h00);
   endtask

   // Rounds of an optional envelope setup and trigger, then a burst of ticks with interleaved events.
   task automatic test_random_traffic();
      int start;
      int seq_n;
      int ticks;
      int pick;
      start = n_effective;
      seq_n = 0;
      while (n_effective - start < RANDOM_ITEMS) begin
         calm = (seq_n >= 8 && seq_n < 16);
         if ($urandom_range(0, 9) != 0) send_item(ACT_WRITE, REG_ENVELOPE, random_envelope());
         if ($urandom_range(0, 9) != 0)
            send_item(ACT_WRITE, REG_CONTROL, 8'($urandom_range(128, 255)));
         ticks = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 40);
         repeat (ticks) begin
            pick = $urandom_range(0, 99);
            if (pick < 80)      send_item(ACT_TICK, 3'($urandom_range(0, 7)),
                                          8'($urandom_range(0, 255)));
            else if (pick < 88) send_item(ACT_WRITE, REG_ENVELOPE, random_envelope());
            else if (pick < 91) send_item(ACT_EXPIRE, 3'($urandom_range(0, 7)),
                                          8'($urandom_range(0, 255)));
            else if (pick < 94) send_item(ACT_WRITE, REG_CONTROL,
                                          8'($urandom_range(128, 255)));
            else                send_noise();
         end
         seq_n++;
      end
      calm = 1'b0;
   endtask

   always @(negedge clock) rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 20);

   function automatic void check_field(string name, logic [3:0] want, logic [3:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         n_fail++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      rsp_item_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_levels.size() == 0) begin
            $error("result transaction with no expectation pending");
            n_fail++;
         end else begin
            want = expected_levels.pop_front();
            check_field("output_level", want.output_level, rsp_ch.output_level);
            check_field("envelope_level", want.envelope_level, rsp_ch.envelope_level);
            check_field("envelope_running", {3'd0, want.envelope_running},
                        {3'd0, rsp_ch.envelope_running});
            check_field("trigger_taken", {3'd0, want.trigger_taken},
                        {3'd0, rsp_ch.trigger_taken});
         end
      end
   end

   int stall_cycles;

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
         $display("[sound_volume_envelope] ERROR");
         $finish;
      end
   end

   initial begin
      reset             = 1'b1;
      calm              = 1'b0;
      stall_cycles      = 0;
      req_ch.valid      = 1'b0;
      req_ch.action     = ACT_WRITE;
      req_ch.reg_index  = 3'd0;
      req_ch.write_data = 8'h00;
      rsp_ch.ready      = 1'b0;
      n_fail            = 0;
      n_effective       = 0;
      n_writes          = 0;
      n_ticks           = 0;
      n_triggers        = 0;
      n_expiries        = 0;
      n_ignored         = 0;
      clear_channel();
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      test_quiet_events();
      test_dac_off();
      test_zombie_writes();
      test_level_limits();
      test_random_traffic();
      req_ch.valid <= 1'b0;

      while (expected_levels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d envelope writes, %0d triggers, %0d ticks, %0d length expiries",
               n_writes, n_triggers, n_ticks, n_expiries);
      $display("plus %0d ignored or unused transactions, each checked for its result",
               n_ignored);
      if (n_fail == 0)
         $display("[sound_volume_envelope] OK");
      else
         $display("[sound_volume_envelope] ERROR");
      $finish;
   end

endmodule

`default_nettype wire

/* files.f */
rtl/sve_pkg.sv
rtl/sve_if.sv
rtl/sve_core.sv
rtl/sound_volume_envelope.sv
dv/tb.sv
